FILE: hw/rtl/bffa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared constants, request/response types and controller interface types
// for the bitmap first-fit allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

  // Map geometry: the bitmap is stored as rows of ROW_BITS bits
  localparam int MAP_BITS = 1024;
  localparam int ROW_BITS = 8;
  localparam int ROWS     = MAP_BITS / ROW_BITS;
  localparam int IDX_W    = $clog2(MAP_BITS);
  localparam int LEN_W    = IDX_W + 1;
  localparam int BIT_AW   = $clog2(ROW_BITS);
  localparam int ROW_AW   = $clog2(ROWS);

  // Operation codes
  localparam logic [2:0] OP_READ  = 3'd0;
  localparam logic [2:0] OP_SET   = 3'd1;
  localparam logic [2:0] OP_CLEAR = 3'd2;
  localparam logic [2:0] OP_RUN   = 3'd3;
  localparam logic [2:0] OP_FIT   = 3'd4;

  typedef struct packed {
    logic [2:0]       op;
    logic [IDX_W-1:0] bit_index;
    logic             match_value;
    logic [LEN_W-1:0] run_request;
  } req_t;

  typedef struct packed {
    logic             bit_value;
    logic             range_error;
    logic             fit_found;
    logic [IDX_W-1:0] fit_start;
    logic [LEN_W-1:0] longest_run;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // latch a new request and issue the first row read
    logic access;  // row data for a read, set or clear is on the RAM output
    logic scan;    // row data for a search is on the RAM output
    logic finish;  // register the response
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic new_access;    // incoming request is a read, set or clear
    logic new_scan;      // incoming request is a run search or first fit
    logic new_in_range;  // incoming bit index is live
    logic last_row;      // current scan row is the last live row
  } ctrl_stat_t;

endpackage

FILE: hw/rtl/bffa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module bffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/bffa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_ctrl
// Sequencer for the allocator: accepts a request, steps the datapath through
// a row access or a row-by-row scan, then has it register the response.
// ----------------------------------------------------------------------------
module bffa_ctrl
  import bffa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ACCESS = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_REPLY  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy = (state != S_IDLE);

  // Decode next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (stat.new_access && stat.new_in_range) begin
            state_next = S_ACCESS;
          end else if (stat.new_scan) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_REPLY;
          end
        end
      end
      S_ACCESS: begin
        cmd.access = 1'b1;
        state_next = S_REPLY;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.last_row) begin
          state_next = S_REPLY;
        end
      end
      S_REPLY: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hw/rtl/bffa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_dp
// Allocator datapath: live-size register, bitmap RAM with per-row valid bits,
// read-modify-write of one bit, and an eight-bit-per-cycle run scanner.
// ----------------------------------------------------------------------------
module bffa_dp
  import bffa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  req_t             req,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_data,
  input  ctrl_cmd_t        cmd,
  output ctrl_stat_t       stat,
  output logic             done,
  output rsp_t             rsp
);

  logic [LEN_W-1:0]    bits_in_use;
  logic [LEN_W-1:0]    live;
  logic [ROW_AW-1:0]   last_row;

  req_t                req_q;
  logic                in_range_q;
  logic                bit_q;
  logic [ROW_AW-1:0]   row_q;
  logic [ROW_AW-1:0]   rd_row;
  logic [ROWS-1:0]     row_valid;

  logic [LEN_W-1:0]    run;
  logic [LEN_W-1:0]    best;
  logic                found;
  logic [IDX_W-1:0]    fit_end;
  logic [LEN_W-1:0]    run_next;
  logic [LEN_W-1:0]    best_next;
  logic                found_next;
  logic [IDX_W-1:0]    fit_end_next;

  logic [ROW_AW-1:0]   raddr;
  logic [ROW_BITS-1:0] ram_q;
  logic [ROW_BITS-1:0] row_data;
  logic [ROW_BITS-1:0] wdata;
  logic                we;
  logic [LEN_W-1:0]    start_sum;

  // Live size register, written from the configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      bits_in_use <= LEN_W'(MAP_BITS);
    end else if (cfg_we) begin
      bits_in_use <= cfg_data;
    end
  end

  // Clamp the live size into one to MAP_BITS
  always_comb begin
    live = bits_in_use;
    if (bits_in_use == '0) begin
      live = LEN_W'(1);
    end else if (bits_in_use > LEN_W'(MAP_BITS)) begin
      live = LEN_W'(MAP_BITS);
    end
  end

  always_comb begin
    logic [LEN_W-1:0] live_m1;
    live_m1  = live - LEN_W'(1);
    last_row = live_m1[IDX_W-1:BIT_AW];
  end

  // Status for the controller
  assign stat.new_access   = req.op inside {OP_READ, OP_SET, OP_CLEAR};
  assign stat.new_scan     = req.op inside {OP_RUN, OP_FIT};
  assign stat.new_in_range = ({1'b0, req.bit_index} < live);
  assign stat.last_row     = (row_q == last_row);

  // Pick the RAM read row: the addressed row at load, the next row in a scan
  always_comb begin
    raddr = row_q + ROW_AW'(1);
    if (cmd.load) begin
      raddr = stat.new_access ? req.bit_index[IDX_W-1:BIT_AW] : '0;
    end
  end

  // A row never written reads as all free
  assign row_data = row_valid[rd_row] ? ram_q : '0;

  // Modify one bit for set and clear
  always_comb begin
    wdata = row_data;
    wdata[req_q.bit_index[BIT_AW-1:0]] = (req_q.op == OP_SET);
  end
  assign we = cmd.access && (req_q.op inside {OP_SET, OP_CLEAR});

  bffa_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (req_q.bit_index[IDX_W-1:BIT_AW]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // Mark rows once written
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (we) begin
      row_valid[req_q.bit_index[IDX_W-1:BIT_AW]] <= 1'b1;
    end
  end

  // Advance the run trackers over the eight bits of the current row
  always_comb begin
    logic [IDX_W-1:0] pos_v;
    logic             target_v;
    logic             is_fit_v;
    run_next     = run;
    best_next    = best;
    found_next   = found;
    fit_end_next = fit_end;
    is_fit_v     = (req_q.op == OP_FIT);
    target_v     = is_fit_v ? 1'b0 : req_q.match_value;
    for (int b = 0; b < ROW_BITS; b++) begin
      pos_v = {row_q, BIT_AW'(b)};
      if (({1'b0, pos_v} < live) && !found_next) begin
        if (row_data[b] == target_v) begin
          run_next = run_next + LEN_W'(1);
          if (run_next > best_next) begin
            best_next = run_next;
          end
          if (is_fit_v && (run_next == req_q.run_request)) begin
            found_next   = 1'b1;
            fit_end_next = pos_v;
          end
        end else begin
          run_next = '0;
        end
      end
    end
  end

  // Row counter and scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= '0;
      best  <= '0;
      found <= 1'b0;
      row_q <= '0;
    end else if (cmd.load) begin
      run   <= '0;
      best  <= '0;
      found <= 1'b0;
      row_q <= '0;
    end else if (cmd.scan) begin
      run   <= run_next;
      best  <= best_next;
      found <= found_next;
      row_q <= row_q + ROW_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    rd_row <= raddr;
    if (cmd.load) begin
      req_q      <= req;
      in_range_q <= stat.new_in_range;
      bit_q      <= 1'b0;
    end
    if (cmd.scan) begin
      fit_end <= fit_end_next;
    end
    if (cmd.access) begin
      bit_q <= row_data[req_q.bit_index[BIT_AW-1:0]];
    end
  end

  // Start of the found run: end + 1 - request
  assign start_sum = {1'b0, fit_end} + LEN_W'(1) - req_q.run_request;

  // Register the response and its strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.bit_value   <= (req_q.op == OP_READ) && in_range_q && bit_q;
      rsp.range_error <= (req_q.op inside {OP_READ, OP_SET, OP_CLEAR}) && !in_range_q;
      rsp.fit_found   <= (req_q.op == OP_FIT) && found;
      rsp.fit_start   <= ((req_q.op == OP_FIT) && found) ? start_sum[IDX_W-1:0] : '0;
      rsp.longest_run <= (req_q.op == OP_RUN) ? best : '0;
    end
  end

  // A found fit excludes the other result kinds
  assert property (@(posedge clk) disable iff (rst)
    (done && rsp.fit_found) |-> (!rsp.range_error && rsp.longest_run == '0))
    else $error("fit result carries other result fields");

  // Once a fit is found it is kept until the next request
  assert property (@(posedge clk) disable iff (rst)
    (found && !cmd.load) |=> found)
    else $error("found flag dropped during scan");

  // The current run never exceeds the best run seen
  assert property (@(posedge clk) disable iff (rst)
    run <= best)
    else $error("current run longer than best run");

  // The scan never steps past the last live row
  assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> (row_q <= last_row))
    else $error("scan row beyond live size");

endmodule

FILE: hw/rtl/bitmap_first_fit_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator_unit
// Bitmap allocator with bit read/set/clear, longest-run and first-fit search.
// ----------------------------------------------------------------------------
// Read, set, clear: the request is latched and the addressed row is read,
// the bit is read or written, then done strobes (access skipped for bad index or op).
// Longest run, first fit: the scanner consumes one 8-bit RAM row per cycle
// through the last live row, then done strobes. One request in flight at a time.
// Reset clears the map through per-row valid bits at once (no clearing pass)
// and sets the live size to 1024. The receiver cannot stall responses.
module bitmap_first_fit_allocator_unit
  import bffa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             req,
  output logic             done,
  output rsp_t             rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // Accept register writes only when no request is in flight or arriving
  assign cfg_ready = !busy && !start;

  bffa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  bffa_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .done     (done),
    .rsp      (rsp)
  );

endmodule
